[rtl/core/keccak_p400_permutation_core_defines.svh]
// Assertion helpers for the permutation core.
// All assertions sample on i_clk and are off while i_rst_n is low.
`ifndef KECCAK_P400_PERMUTATION_CORE_DEFINES_SVH
`define KECCAK_P400_PERMUTATION_CORE_DEFINES_SVH

// Same-cycle implication.
`define KP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define KP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/kp400_pkg.sv]
package kp400_pkg;

    localparam int TOTAL_ROUNDS       = 20;
    localparam int LANE_COUNT         = 25;
    localparam int LANE_W             = 16;
    localparam int CNT_W              = 5;
    localparam int DEFAULT_MAX_ROUNDS = 20;

    typedef logic [LANE_W-1:0]               t_lane;
    typedef logic [LANE_COUNT-1:0][LANE_W-1:0] t_state;

    // iota constants, low 16 bits of the Keccak round constants
    localparam t_lane RC [TOTAL_ROUNDS] = '{
        16'h0001, 16'h8082, 16'h808a, 16'h8000, 16'h808b, 16'h0001, 16'h8081, 16'h8009,
        16'h008a, 16'h0088, 16'h8009, 16'h000a, 16'h808b, 16'h008b, 16'h8089, 16'h8003,
        16'h8002, 16'h0080, 16'h800a, 16'h000a
    };

    // rho offsets mod 16, by source lane x+5y
    localparam logic [3:0] ROT [LANE_COUNT] = '{
        4'd0, 4'd1, 4'd14, 4'd12, 4'd11, 4'd4, 4'd12, 4'd6, 4'd7, 4'd4,
        4'd3, 4'd10, 4'd11, 4'd9, 4'd7, 4'd9, 4'd13, 4'd15, 4'd5, 4'd8,
        4'd2, 4'd2, 4'd13, 4'd8, 4'd14
    };

    // pi destination: lane (x,y) goes to (y, 2x+3y)
    localparam logic [4:0] PI_DST [LANE_COUNT] = '{
        5'd0, 5'd10, 5'd20, 5'd5, 5'd15, 5'd16, 5'd1, 5'd11, 5'd21, 5'd6,
        5'd7, 5'd17, 5'd2, 5'd12, 5'd22, 5'd23, 5'd8, 5'd18, 5'd3, 5'd13,
        5'd14, 5'd24, 5'd9, 5'd19, 5'd4
    };

    function automatic t_lane kp_rotl(input t_lane v, input logic [3:0] r);
        logic [2*LANE_W-1:0] w;
        w = {v, v} << r;
        return w[2*LANE_W-1:LANE_W];
    endfunction

    // One full round: theta, rho, pi, chi, iota.
    function automatic t_state kp_round(input t_state a, input t_lane rc);
        t_lane  c [5];
        t_lane  d [5];
        t_state t;
        t_state b;
        t_state o;
        int     x;
        int     y;
        int     xp1;
        int     xp2;
        int     xm1;
        for (x = 0; x < 5; x++) begin
            c[x] = a[x] ^ a[x+5] ^ a[x+10] ^ a[x+15] ^ a[x+20];
        end
        for (x = 0; x < 5; x++) begin
            xp1  = (x == 4) ? 0 : x + 1;
            xm1  = (x == 0) ? 4 : x - 1;
            d[x] = {c[xp1][LANE_W-2:0], c[xp1][LANE_W-1]} ^ c[xm1];
        end
        for (y = 0; y < 5; y++) begin
            for (x = 0; x < 5; x++) begin
                t[x+5*y] = a[x+5*y] ^ d[x];
            end
        end
        for (x = 0; x < LANE_COUNT; x++) begin
            b[PI_DST[x]] = kp_rotl(t[x], ROT[x]);
        end
        for (y = 0; y < 5; y++) begin
            for (x = 0; x < 5; x++) begin
                xp1 = (x == 4) ? 0 : x + 1;
                xp2 = (x >= 3) ? x - 3 : x + 2;
                o[x+5*y] = b[x+5*y] ^ (~b[xp1+5*y] & b[xp2+5*y]);
            end
        end
        o[0] = o[0] ^ rc;
        return o;
    endfunction

endpackage

[rtl/core/keccak_p400_permutation_core.sv]
// Keccak-p[400] permutation core, last n rounds. Each item carries the 25
// 16-bit lanes (lane x+5y, four lanes per 64-bit word, lowest lane in the
// low bits) and a round count n; the result is the state after rounds
// 20-n through 19. n = 0 passes the state through, n above MAX_ROUNDS is
// taken as MAX_ROUNDS. The core is a pipeline of MAX_ROUNDS stages, one
// Keccak round per stage, each stage hardwired to its own round constant;
// a stage whose round lies before the item's first round just forwards
// the state. Every item passes through all MAX_ROUNDS stages regardless
// of n, and a new item can be taken every cycle while the output is not
// stalled. The last stage is the output register. When the output is
// stalled the whole pipeline holds, so o_stall follows i_stall while an
// item sits at the output.
`include "keccak_p400_permutation_core_defines.svh"

module keccak_p400_permutation_core
    import kp400_pkg::*;
#(
    parameter int MAX_ROUNDS = DEFAULT_MAX_ROUNDS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_lanes_in_0_3,
    input  logic [63:0] i_lanes_in_4_7,
    input  logic [63:0] i_lanes_in_8_11,
    input  logic [63:0] i_lanes_in_12_15,
    input  logic [63:0] i_lanes_in_16_19,
    input  logic [63:0] i_lanes_in_20_23,
    input  logic [15:0] i_lane_in_24,
    input  logic [4:0]  i_round_count,

    // result item channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_lanes_out_0_3,
    output logic [63:0] o_lanes_out_4_7,
    output logic [63:0] o_lanes_out_8_11,
    output logic [63:0] o_lanes_out_12_15,
    output logic [63:0] o_lanes_out_16_19,
    output logic [63:0] o_lanes_out_20_23,
    output logic [15:0] o_lane_out_24
);

    localparam int NUM_STAGES = MAX_ROUNDS;
    localparam int LAST       = NUM_STAGES - 1;
    // round index handled by stage 0
    localparam int FIRST_RND  = TOTAL_ROUNDS - MAX_ROUNDS;

    // pipeline registers: state, saturated count and valid per stage
    t_state                r_state [NUM_STAGES];
    logic [CNT_W-1:0]      r_cnt   [NUM_STAGES];
    logic [NUM_STAGES-1:0] r_valid;
    t_state                n_state [NUM_STAGES];

    logic             adv;      // whole pipeline moves this cycle
    t_state           in_state;
    logic [CNT_W-1:0] in_cnt;   // count clamped to MAX_ROUNDS

    // Global hold: only a stalled item at the output freezes the pipe.
    assign adv     = !(r_valid[LAST] && i_stall);
    assign o_stall = !adv;

    assign in_state = {i_lane_in_24, i_lanes_in_20_23, i_lanes_in_16_19,
                       i_lanes_in_12_15, i_lanes_in_8_11, i_lanes_in_4_7,
                       i_lanes_in_0_3};
    assign in_cnt   = (i_round_count > CNT_W'(MAX_ROUNDS)) ? CNT_W'(MAX_ROUNDS)
                                                          : i_round_count;

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_stage
        t_state           w_in;
        logic [CNT_W-1:0] w_cnt;
        logic             w_vld;
        logic             w_act;

        if (s == 0) begin : g_head
            assign w_in  = in_state;
            assign w_cnt = in_cnt;
            assign w_vld = i_valid;
        end else begin : g_body
            assign w_in  = r_state[s-1];
            assign w_cnt = r_cnt[s-1];
            assign w_vld = r_valid[s-1];
        end

        // stage s runs round FIRST_RND+s, which belongs to the item's last
        // n rounds when n >= MAX_ROUNDS - s
        assign w_act      = (w_cnt >= CNT_W'(MAX_ROUNDS - s));
        assign n_state[s] = w_act ? kp_round(w_in, RC[FIRST_RND + s]) : w_in;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (adv) begin
                r_valid[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_state[s] <= n_state[s];
                r_cnt[s]   <= w_cnt;
            end
        end
    end

    assign o_valid           = r_valid[LAST];
    assign o_lanes_out_0_3   = r_state[LAST][3:0];
    assign o_lanes_out_4_7   = r_state[LAST][7:4];
    assign o_lanes_out_8_11  = r_state[LAST][11:8];
    assign o_lanes_out_12_15 = r_state[LAST][15:12];
    assign o_lanes_out_16_19 = r_state[LAST][19:16];
    assign o_lanes_out_20_23 = r_state[LAST][23:20];
    assign o_lane_out_24     = r_state[LAST][24];

    // ---- assertions ----
    `KP_ASSERT_NOW(a_stall_needs_item, o_stall, o_valid,
        "input stalled without a held result item")

    `KP_ASSERT_NEXT(a_accept_enters, i_valid && !o_stall, r_valid[0],
        "accepted item did not enter stage 0")

    `KP_ASSERT_NOW(a_cnt_clamped, r_valid[0], r_cnt[0] <= CNT_W'(MAX_ROUNDS),
        "round count above MAX_ROUNDS in pipeline")

    for (genvar s = 0; s < NUM_STAGES; s++) begin : g_chk
        `KP_ASSERT_NEXT(a_skip_stage, adv && g_stage[s].w_vld && !g_stage[s].w_act,
            r_state[s] == $past(g_stage[s].w_in),
            "skipped round altered the state")
    end

endmodule
